### hdl/slt_pkg.sv
// Shared types and codes for the sorted list table.
`default_nettype none

package slt_pkg;

  // Command codes carried by an input word.
  typedef enum logic [2:0] {
    CMD_INSERT    = 3'd0,
    CMD_DELETE    = 3'd1,
    CMD_SEARCH    = 3'd2,
    CMD_LAST      = 3'd3,
    CMD_NTH       = 3'd4,
    CMD_LIST_ASC  = 3'd5,
    CMD_LIST_DESC = 3'd6
  } cmd_e;

  // Status codes carried by a result word.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  localparam int unsigned ValueW = 32;
  localparam int unsigned PosW   = 4;
  localparam int unsigned CountW = 5;

  // One result word as held in the output register.
  typedef struct packed {
    status_e                   status;
    logic signed [ValueW-1:0]  value;
    logic        [CountW-1:0]  count;
    logic                      last;
  } out_word_t;

endpackage

`default_nettype wire

### hdl/slt_store.sv
// Entry store: one write port, one read port with registered read data.
`default_nettype none

module slt_store #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  wire logic                              clk_i,
  input  wire logic                              wr_en_i,
  input  wire logic [AW-1:0]                     wr_addr_i,
  input  wire logic signed [slt_pkg::ValueW-1:0] wr_data_i,
  input  wire logic [AW-1:0]                     rd_addr_i,
  output logic signed [slt_pkg::ValueW-1:0]      rd_data_o
);

  logic signed [slt_pkg::ValueW-1:0] mem [DEPTH];
  logic signed [slt_pkg::ValueW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

### hdl/sorted_list_table.sv
// Top level of the sorted list table: command sequencer around the entry store.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-----------------------------------------------
//   in      | input     | in_valid_i/in_ready_o | command_i, value_i, position_i
//   out     | output    | out_valid_o/out_ready_i | status_o, result_value_o, entry_count_o,
//           |           |                       |   last_of_run_o
//
// Each command walks the store one entry at a time: insert over the entries moved, delete
// over the stored entries, search over the entries scanned and a list over all its entries;
// the refused and empty cases need no walk, and last and nth read one entry. The single store
// read port steps one entry per cycle while the output is free. Reset clears the entry
// count and the sequencer; entry contents stay unknown and are never read before written.
// A stalled output holds the sequencer in its emit state; one finished word may wait in
// the output register while a new command is taken.
`default_nettype none

module sorted_list_table #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [2:0]                        command_i,
  input  wire logic signed [slt_pkg::ValueW-1:0] value_i,
  input  wire logic [slt_pkg::PosW-1:0]          position_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [1:0]                             status_o,
  output logic signed [slt_pkg::ValueW-1:0]      result_value_o,
  output logic [slt_pkg::CountW-1:0]             entry_count_o,
  output logic                                   last_of_run_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_INS  = 8'b0000_0010,
    S_INS0 = 8'b0000_0100,
    S_DEL  = 8'b0000_1000,
    S_SRCH = 8'b0001_0000,
    S_READ = 8'b0010_0000,
    S_LIST = 8'b0100_0000,
    S_RESP = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [AW-1:0] ptr_q, ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          found_q, found_d;
  logic          desc_q, desc_d;
  logic signed [slt_pkg::ValueW-1:0] val_q, val_d;

  // Pending single result, loaded ahead of the response state and sent by it.
  slt_pkg::status_e                  rsp_st_q, rsp_st_d;
  logic signed [slt_pkg::ValueW-1:0] rsp_val_q, rsp_val_d;

  slt_pkg::out_word_t out_q, out_d;
  logic               out_valid_q, out_valid_d;

  logic                              wr_en;
  logic [AW-1:0]                     wr_addr;
  logic signed [slt_pkg::ValueW-1:0] wr_data;
  logic signed [slt_pkg::ValueW-1:0] rd_data;

  logic in_fire;
  logic slot_free;
  logic at_tail;
  logic hit;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;
  // rd_data always holds the entry at ptr_q: the read address is ptr_d.
  assign at_tail    = ((CW'(ptr_q) + CW'(1)) == count_q);
  assign hit        = (rd_data == val_q);

  slt_store #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_store (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_addr_i(ptr_d),
    .rd_data_o(rd_data)
  );

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    count_d     = count_q;
    found_d     = found_q;
    desc_d      = desc_q;
    val_d       = val_q;
    rsp_st_d    = rsp_st_q;
    rsp_val_d   = rsp_val_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    wr_en       = 1'b0;
    wr_addr     = ptr_q;
    wr_data     = val_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          val_d     = value_i;
          rsp_val_d = value_i;
          found_d   = 1'b0;
          unique case (slt_pkg::cmd_e'(command_i))
            slt_pkg::CMD_INSERT: begin
              if (count_q >= CW'(DEPTH)) begin
                rsp_st_d = slt_pkg::ST_FULL;
                state_d  = S_RESP;
              end else if (count_q == '0) begin
                // Empty table: place the word at the head right away.
                wr_en    = 1'b1;
                wr_addr  = '0;
                wr_data  = value_i;
                count_d  = count_q + CW'(1);
                rsp_st_d = slt_pkg::ST_OK;
                state_d  = S_RESP;
              end else begin
                ptr_d   = AW'(count_q - CW'(1));
                state_d = S_INS;
              end
            end
            slt_pkg::CMD_DELETE, slt_pkg::CMD_SEARCH: begin
              if (count_q == '0) begin
                rsp_st_d = slt_pkg::ST_EMPTY;
                state_d  = S_RESP;
              end else begin
                ptr_d   = '0;
                state_d = (slt_pkg::cmd_e'(command_i) == slt_pkg::CMD_DELETE) ? S_DEL : S_SRCH;
              end
            end
            slt_pkg::CMD_LAST: begin
              if (count_q == '0) begin
                rsp_st_d = slt_pkg::ST_EMPTY;
                state_d  = S_RESP;
              end else begin
                ptr_d   = AW'(count_q - CW'(1));
                state_d = S_READ;
              end
            end
            slt_pkg::CMD_NTH: begin
              if (count_q == '0) begin
                rsp_st_d = slt_pkg::ST_EMPTY;
                state_d  = S_RESP;
              end else if ({{(32-slt_pkg::PosW){1'b0}}, position_i} >=
                           {{(32-CW){1'b0}}, count_q}) begin
                rsp_st_d = slt_pkg::ST_NOTFOUND;
                state_d  = S_RESP;
              end else begin
                ptr_d   = AW'(position_i);
                state_d = S_READ;
              end
            end
            slt_pkg::CMD_LIST_ASC, slt_pkg::CMD_LIST_DESC: begin
              if (count_q == '0) begin
                rsp_st_d = slt_pkg::ST_EMPTY;
                state_d  = S_RESP;
              end else begin
                desc_d  = (slt_pkg::cmd_e'(command_i) == slt_pkg::CMD_LIST_DESC);
                ptr_d   = (slt_pkg::cmd_e'(command_i) == slt_pkg::CMD_LIST_DESC) ?
                          AW'(count_q - CW'(1)) : '0;
                state_d = S_LIST;
              end
            end
            default: begin
              // Unused code: drop the word, no result.
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_INS: begin
        // Walk down from the tail, moving every entry not below the new value up by one.
        wr_en   = 1'b1;
        wr_addr = ptr_q + AW'(1);
        if (rd_data >= val_q) begin
          wr_data = rd_data;
          if (ptr_q == '0) begin
            state_d = S_INS0;
          end else begin
            ptr_d = ptr_q - AW'(1);
          end
        end else begin
          wr_data  = val_q;
          count_d  = count_q + CW'(1);
          rsp_st_d = slt_pkg::ST_OK;
          state_d  = S_RESP;
        end
      end

      S_INS0: begin
        wr_en    = 1'b1;
        wr_addr  = '0;
        wr_data  = val_q;
        count_d  = count_q + CW'(1);
        rsp_st_d = slt_pkg::ST_OK;
        state_d  = S_RESP;
      end

      S_DEL: begin
        // After the first match, move every later entry down by one.
        if (found_q) begin
          wr_en   = 1'b1;
          wr_addr = ptr_q - AW'(1);
          wr_data = rd_data;
        end else if (hit) begin
          found_d = 1'b1;
        end
        if (at_tail) begin
          if (found_q || hit) begin
            count_d  = count_q - CW'(1);
            rsp_st_d = slt_pkg::ST_OK;
          end else begin
            rsp_st_d = slt_pkg::ST_NOTFOUND;
          end
          state_d = S_RESP;
        end else begin
          ptr_d = ptr_q + AW'(1);
        end
      end

      S_SRCH: begin
        if (hit) begin
          rsp_st_d = slt_pkg::ST_OK;
          state_d  = S_RESP;
        end else if (at_tail) begin
          rsp_st_d = slt_pkg::ST_NOTFOUND;
          state_d  = S_RESP;
        end else begin
          ptr_d = ptr_q + AW'(1);
        end
      end

      S_READ: begin
        rsp_st_d  = slt_pkg::ST_OK;
        rsp_val_d = rd_data;
        state_d   = S_RESP;
      end

      S_LIST: begin
        // Hold the pointer while the output is stalled; the read repeats the same entry.
        if (slot_free) begin
          out_valid_d  = 1'b1;
          out_d.status = slt_pkg::ST_OK;
          out_d.value  = rd_data;
          out_d.count  = slt_pkg::CountW'(count_q);
          out_d.last   = desc_q ? (ptr_q == '0) : at_tail;
          if (desc_q ? (ptr_q == '0) : at_tail) begin
            state_d = S_IDLE;
          end else begin
            ptr_d = desc_q ? (ptr_q - AW'(1)) : (ptr_q + AW'(1));
          end
        end
      end

      S_RESP: begin
        if (slot_free) begin
          out_valid_d  = 1'b1;
          out_d.status = rsp_st_q;
          out_d.value  = (rsp_st_q == slt_pkg::ST_OK) ? rsp_val_q : '0;
          out_d.count  = slt_pkg::CountW'(count_q);
          out_d.last   = 1'b1;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      ptr_q       <= '0;
      found_q     <= 1'b0;
      desc_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      ptr_q       <= ptr_d;
      found_q     <= found_d;
      desc_q      <= desc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q     <= val_d;
    rsp_st_q  <= rsp_st_d;
    rsp_val_q <= rsp_val_d;
    out_q     <= out_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_q.status;
  assign result_value_o = out_q.value;
  assign entry_count_o  = out_q.count;
  assign last_of_run_o  = out_q.last;

endmodule

`default_nettype wire

### hdl/slt_checker.sv
// Port-level checks for the sorted list table, bound to the top level.
`default_nettype none

module slt_checker #(
  parameter int unsigned DEPTH = 16
) (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_ready_o,
  input wire logic                              out_valid_o,
  input wire logic                              out_ready_i,
  input wire logic [1:0]                        status_o,
  input wire logic signed [slt_pkg::ValueW-1:0] result_value_o,
  input wire logic [slt_pkg::CountW-1:0]        entry_count_o,
  input wire logic                              last_of_run_o
);

  // A stalled result word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_value_o) &&
      $stable(status_o) && $stable(last_of_run_o))
    else $error("stalled result word changed");

  // Any status other than ok ends its run and carries a zero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != slt_pkg::ST_OK) |-> last_of_run_o && (result_value_o == '0))
    else $error("non-ok result not final or value nonzero");

  // A list run in progress keeps new commands out.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_run_o |-> !in_ready_o)
    else $error("command taken in the middle of a list");

  // The reported count never exceeds the table depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({{(32-slt_pkg::CountW){1'b0}}, entry_count_o} <= DEPTH))
    else $error("entry count beyond depth");

endmodule

bind sorted_list_table slt_checker #(
  .DEPTH(DEPTH)
) u_slt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .status_o      (status_o),
  .result_value_o(result_value_o),
  .entry_count_o (entry_count_o),
  .last_of_run_o (last_of_run_o)
);

`default_nettype wire

### dv/sorted_list_table_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the sorted list table: shadow table, expected result words, field checks.
module sorted_list_table_checker #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic [2:0]                          command_i,
  input  logic signed [slt_pkg::ValueW-1:0]   value_i,
  input  logic [slt_pkg::PosW-1:0]            position_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic [1:0]                          status_i,
  input  logic signed [slt_pkg::ValueW-1:0]   result_value_i,
  input  logic [slt_pkg::CountW-1:0]          entry_count_i,
  input  logic                                last_of_run_i,
  output int unsigned                         fault_count_o,
  output int unsigned                         pending_o
);

  // Shadow copy of the table, ascending, and its fill level.
  logic signed [slt_pkg::ValueW-1:0] shadow_vals [DEPTH];
  int                                shadow_fill = 0;
  slt_pkg::out_word_t                result_q [$];

  function automatic void queue_result(slt_pkg::status_e st,
                                       logic signed [slt_pkg::ValueW-1:0] v, logic last);
    slt_pkg::out_word_t w;
    w.status = st;
    w.value  = (st == slt_pkg::ST_OK) ? v : '0;
    w.count  = slt_pkg::CountW'(shadow_fill);
    w.last   = last;
    result_q.push_back(w);
  endfunction

  // Return the first slot holding v, or the fill level when none does.
  function automatic int find_first(logic signed [slt_pkg::ValueW-1:0] v);
    int slot;
    slot = shadow_fill;
    for (int i = shadow_fill - 1; i >= 0; i--) begin
      if (shadow_vals[i] == v) slot = i;
    end
    return slot;
  endfunction

  function automatic void apply_command(logic [2:0] cmd, logic signed [slt_pkg::ValueW-1:0] v,
                                        logic [slt_pkg::PosW-1:0] pos);
    int slot;
    case (cmd)
      slt_pkg::CMD_INSERT: begin
        if (shadow_fill >= DEPTH) begin
          queue_result(slt_pkg::ST_FULL, '0, 1'b1);
        end else begin
          slot = 0;
          while (slot < shadow_fill && shadow_vals[slot] < v) slot++;
          for (int k = shadow_fill; k > slot; k--) shadow_vals[k] = shadow_vals[k-1];
          shadow_vals[slot] = v;
          shadow_fill++;
          queue_result(slt_pkg::ST_OK, v, 1'b1);
        end
      end
      slt_pkg::CMD_DELETE, slt_pkg::CMD_SEARCH: begin
        if (shadow_fill == 0) begin
          queue_result(slt_pkg::ST_EMPTY, '0, 1'b1);
        end else begin
          slot = find_first(v);
          if (slot == shadow_fill) begin
            queue_result(slt_pkg::ST_NOTFOUND, '0, 1'b1);
          end else begin
            if (cmd == slt_pkg::CMD_DELETE) begin
              for (int k = slot; k < shadow_fill - 1; k++) shadow_vals[k] = shadow_vals[k+1];
              shadow_fill--;
            end
            queue_result(slt_pkg::ST_OK, v, 1'b1);
          end
        end
      end
      slt_pkg::CMD_LAST: begin
        if (shadow_fill == 0) queue_result(slt_pkg::ST_EMPTY, '0, 1'b1);
        else queue_result(slt_pkg::ST_OK, shadow_vals[shadow_fill-1], 1'b1);
      end
      slt_pkg::CMD_NTH: begin
        if (shadow_fill == 0) queue_result(slt_pkg::ST_EMPTY, '0, 1'b1);
        else if (int'(pos) >= shadow_fill) queue_result(slt_pkg::ST_NOTFOUND, '0, 1'b1);
        else queue_result(slt_pkg::ST_OK, shadow_vals[pos], 1'b1);
      end
      slt_pkg::CMD_LIST_ASC, slt_pkg::CMD_LIST_DESC: begin
        if (shadow_fill == 0) begin
          queue_result(slt_pkg::ST_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < shadow_fill; i++) begin
            slot = (cmd == slt_pkg::CMD_LIST_ASC) ? i : shadow_fill - 1 - i;
            queue_result(slt_pkg::ST_OK, shadow_vals[slot], i == shadow_fill - 1);
          end
        end
      end
      default: ;  // unused code: no result words
    endcase
  endfunction

  always @(posedge clk_i) begin
    slt_pkg::out_word_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) apply_command(command_i, value_i, position_i);
      if (out_valid_i && out_ready_i) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result word: status %0d value %0d count %0d last %0d",
                   $time, status_i, result_value_i, entry_count_i, last_of_run_i);
          fault_count_o++;
        end else begin
          want = result_q.pop_front();
          if (status_i !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status_i);
            fault_count_o++;
          end
          if (result_value_i !== want.value) begin
            $display("%0t: result_value expected %0d actual %0d",
                     $time, want.value, result_value_i);
            fault_count_o++;
          end
          if (entry_count_i !== want.count) begin
            $display("%0t: entry_count expected %0d actual %0d",
                     $time, want.count, entry_count_i);
            fault_count_o++;
          end
          if (last_of_run_i !== want.last) begin
            $display("%0t: last_of_run expected %0d actual %0d",
                     $time, want.last, last_of_run_i);
            fault_count_o++;
          end
        end
      end
      pending_o = result_q.size();
    end
  end

endmodule

### dv/sorted_list_table_tb.sv
`timescale 1ns / 100ps
// Testbench top for the sorted list table: clock, reset, command stimulus and verdict.
module sorted_list_table_tb;

  localparam int unsigned Depth = 16;
  // Command code that the block must drop without a result word.
  localparam logic [2:0] CmdUnused = 3'd7;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic [2:0]                        command = '0;
  logic signed [slt_pkg::ValueW-1:0] value = '0;
  logic [slt_pkg::PosW-1:0]          position = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic [1:0]                        status;
  logic signed [slt_pkg::ValueW-1:0] result_value;
  logic [slt_pkg::CountW-1:0]        entry_count;
  logic                              last_of_run;
  int unsigned                       fault_count;
  int unsigned                       pending;

  // Set during a phase where neither side idles.
  logic                              quiet = 1'b0;
  logic signed [slt_pkg::ValueW-1:0] value_pool [8];

  always #10 clk = ~clk;

  sorted_list_table #(
    .DEPTH(Depth)
  ) DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .command_i     (command),
    .value_i       (value),
    .position_i    (position),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .status_o      (status),
    .result_value_o(result_value),
    .entry_count_o (entry_count),
    .last_of_run_o (last_of_run)
  );

  sorted_list_table_checker #(
    .DEPTH(Depth)
  ) u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .command_i     (command),
    .value_i       (value),
    .position_i    (position),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .status_i      (status),
    .result_value_i(result_value),
    .entry_count_i (entry_count),
    .last_of_run_i (last_of_run),
    .fault_count_o (fault_count),
    .pending_o     (pending)
  );

  // Draw the idle cycles ahead of one word; none while the quiet phase runs.
  function automatic int unsigned idle_gap();
    return quiet ? 0 : $urandom_range(0, 8);
  endfunction

  // Offer one command word at the falling edge and hold it until the block takes it.
  // With no gap, valid simply stays high into the next word.
  task automatic send_word(input logic [2:0] cmd, input logic signed [slt_pkg::ValueW-1:0] v,
                           input logic [slt_pkg::PosW-1:0] pos);
    int unsigned gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    value    <= v;
    position <= pos;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Result side: stall a random number of cycles ahead of every result word.
  initial begin
    int unsigned stall;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = idle_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int unsigned phase_items;
    int unsigned ins_share;
    int unsigned del_share;
    int unsigned roll;
    logic [2:0]  cmd;
    logic signed [slt_pkg::ValueW-1:0] v;

    // Hold reset low, then release it on a falling edge.
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: every command on the empty table, then the value extremes,
    // duplicates, position bounds and both delete outcomes.
    send_word(slt_pkg::CMD_DELETE,    0, 0);
    send_word(slt_pkg::CMD_SEARCH,    0, 0);
    send_word(slt_pkg::CMD_LAST,      0, 0);
    send_word(slt_pkg::CMD_NTH,       0, 0);
    send_word(slt_pkg::CMD_LIST_ASC,  0, 0);
    send_word(slt_pkg::CMD_LIST_DESC, 0, 0);
    send_word(CmdUnused,              0, 0);
    send_word(slt_pkg::CMD_INSERT,    32'sh7FFF_FFFF, 0);
    send_word(slt_pkg::CMD_INSERT,    32'sh8000_0000, 0);
    send_word(slt_pkg::CMD_INSERT,    0, 0);
    send_word(slt_pkg::CMD_INSERT,    -1, 0);
    send_word(slt_pkg::CMD_INSERT,    5, 0);
    send_word(slt_pkg::CMD_INSERT,    5, 4'd15);
    send_word(slt_pkg::CMD_SEARCH,    5, 0);
    send_word(slt_pkg::CMD_SEARCH,    6, 0);
    send_word(slt_pkg::CMD_NTH,       0, 4'd0);
    send_word(slt_pkg::CMD_NTH,       0, 4'd5);
    send_word(slt_pkg::CMD_NTH,       0, 4'd6);
    send_word(slt_pkg::CMD_NTH,       0, 4'd15);
    send_word(slt_pkg::CMD_LAST,      0, 0);
    send_word(slt_pkg::CMD_LIST_ASC,  0, 0);
    send_word(slt_pkg::CMD_LIST_DESC, 0, 0);
    send_word(slt_pkg::CMD_DELETE,    7, 0);
    send_word(slt_pkg::CMD_DELETE,    5, 0);
    send_word(slt_pkg::CMD_DELETE,    32'sh8000_0000, 0);

    // Random phases: fill toward full, churn, drain toward empty, twice over.
    // Values come mostly from a small pool so deletes and searches hit.
    value_pool[0] = 32'sh7FFF_FFFF;
    value_pool[1] = 32'sh8000_0000;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       begin ins_share = 70; del_share = 10; end
        1:       begin ins_share = 30; del_share = 25; end
        2:       begin ins_share = 10; del_share = 60; end
        3:       begin ins_share = 75; del_share = 5;  end
        4:       begin ins_share = 35; del_share = 30; end
        default: begin ins_share = 5;  del_share = 70; end
      endcase
      quiet = (phase == 4);
      for (int i = 2; i < 8; i++) begin
        if ($urandom_range(0, 3) == 0) value_pool[i] = $urandom;
        else value_pool[i] = int'($urandom_range(0, 16)) - 8;
      end
      phase_items = 0;
      while (phase_items < 41) begin
        roll = $urandom_range(0, 99);
        if (roll < 3) cmd = CmdUnused;
        else if (roll < 3 + ins_share) cmd = slt_pkg::CMD_INSERT;
        else if (roll < 3 + ins_share + del_share) cmd = slt_pkg::CMD_DELETE;
        else cmd = 3'($urandom_range(slt_pkg::CMD_SEARCH, slt_pkg::CMD_LIST_DESC));
        if ($urandom_range(0, 3) == 0) v = $urandom;
        else v = value_pool[$urandom_range(0, 7)];
        send_word(cmd, v, slt_pkg::PosW'($urandom_range(0, 15)));
        // Dropped codes do not count toward the phase.
        if (cmd != CmdUnused) phase_items++;
      end
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    // Drain: wait for every expected word, then keep watching for strays before the verdict.
    wait (pending == 0);
    repeat (40) @(posedge clk);
    if (fault_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
